FILE: hw/rtl/hex_dump_formatter_defines.svh
// ----------------------------------------------------------------------------
// Hex dump formatter assertion macros
// Shared concurrent assertion forms, clocked on rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_DUMP_FORMATTER_DEFINES_SVH
`define HEX_DUMP_FORMATTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hdf_pkg.sv
// ----------------------------------------------------------------------------
// Hex dump formatter package
// Job descriptor, sequencer step codes, character constants and helpers.
// ----------------------------------------------------------------------------
package hdf_pkg;

    // Width of the running byte offset; it wraps at this many bits.
    localparam int OFFSET_W = 28;
    // Width that the offset is zero-extended to before digit selection.
    localparam int WIDE_W = 64;
    // Number of jobs that the queue between front and back holds.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes of an input transaction.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // ASCII codes used in the dump text.
    localparam logic [6:0] CHAR_NL    = 7'h0a;
    localparam logic [6:0] CHAR_SP    = 7'h20;
    localparam logic [6:0] CHAR_DIGIT = 7'd48;
    localparam logic [6:0] CHAR_ALPHA = 7'd87;

    // One classified input item, as the back end needs it.
    typedef struct packed {
        logic                is_end;
        logic                nl_pre;
        logic                line_start;
        logic                grp_sp;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          data;
    } t_job;

    // Write side of the job queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_wr;

    // Read side of the job queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_rd;

    // Character steps of the back-end sequencer.
    typedef enum logic [3:0] {
        S_START,
        S_NL_PRE,
        S_DIGIT,
        S_SP_OFF,
        S_SP,
        S_HI,
        S_LO,
        S_GRP,
        S_NL_POST
    } t_step;

    // Lowercase hex character of one nibble.
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ext;
        ext = {3'b000, nib};
        return (nib < 4'd10) ? (CHAR_DIGIT + ext) : (CHAR_ALPHA + ext);
    endfunction

endpackage

FILE: hw/rtl/hdf_if.sv
// ----------------------------------------------------------------------------
// Hex dump formatter stream interfaces
// Valid/ready channels for input items and for output characters.
// ----------------------------------------------------------------------------

// Input item channel.
interface hdf_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// Output character channel.
interface hdf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] text_char;
    logic       last_of_run;

    modport source (output valid, output text_char, output last_of_run, input ready);
    modport sink   (input valid, input text_char, input last_of_run, output ready);
endinterface

FILE: hw/rtl/hex_dump_formatter.sv
// ----------------------------------------------------------------------------
// Hex dump formatter
// Turns a stream of bytes and end markers into hex dump text characters.
// ----------------------------------------------------------------------------
// One character goes out per cycle while a job waits and the output register
// is free or being read. A data byte gives a space and two hex digits, plus a
// group space when it closes a group. When it opens a line, the offset digits
// and a space lead it, with a newline before them past the first line: up to
// 13 characters with the default settings. An end item gives a newline, the
// offset digits and a newline, and clears the offset. A back-end sequencer
// drives the single output register. The front end classifies an item in the
// cycle it is accepted and keeps taking items while the two-entry job queue
// has room, so input goes on while earlier characters wait to be taken.

`include "hex_dump_formatter_defines.svh"

module hex_dump_formatter #(
    parameter int OFFSET_DIGITS  = 7,
    parameter int BYTES_PER_LINE = 16,
    parameter int GROUP_SIZE     = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hdf_in_if.sink    i_in,
    hdf_out_if.source o_out
);

    hdf_pkg::t_q_wr w_wr;
    logic           w_wr_ready;
    hdf_pkg::t_q_rd w_rd;
    logic           w_pop;
    logic           w_in_accept;
    logic           w_tail_fire;
    logic           w_tail_ok;

    // Front end: offset tracking and item classification.
    hdf_front #(
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .GROUP_SIZE     (GROUP_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_wr       (w_wr),
        .i_wr_ready (w_wr_ready)
    );

    // Job queue between the two ends.
    hdf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .o_wr_ready (w_wr_ready),
        .o_rd       (w_rd),
        .i_pop      (w_pop)
    );

    // Back end: character sequencer and output register.
    hdf_back #(
        .OFFSET_DIGITS (OFFSET_DIGITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_rd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // Terms used by the checks below.
    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_tail_fire = o_out.valid && o_out.last_of_run;
    assign w_tail_ok   = (o_out.text_char == hdf_pkg::CHAR_NL) ||
                         (o_out.text_char == hdf_pkg::CHAR_SP) ||
                         ((o_out.text_char >= hdf_pkg::CHAR_DIGIT) &&
                          (o_out.text_char <= hdf_pkg::CHAR_DIGIT + 7'd9)) ||
                         ((o_out.text_char >= hdf_pkg::CHAR_ALPHA + 7'd10) &&
                          (o_out.text_char <= hdf_pkg::CHAR_ALPHA + 7'd15));

    // A job is retired only while one is waiting in the queue.
    `HDF_ASSERT_SAME(a_pop_has_job, i_clk, i_rst_n, w_pop, w_rd.valid, "pop from empty queue")

    // An accepted input transaction leaves a job at the queue head.
    `HDF_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_in_accept, w_rd.valid, "accepted item lost")

    // The last character of a run is a newline, a space or a hex digit.
    `HDF_ASSERT_SAME(a_last_char, i_clk, i_rst_n, w_tail_fire, w_tail_ok, "bad final character")

endmodule

FILE: hw/rtl/hdf_front.sv
// ----------------------------------------------------------------------------
// Hex dump formatter front end
// Accepts items, tracks the byte offset and line phase, and classifies each
// item into a job for the back end.
// ----------------------------------------------------------------------------
module hdf_front #(
    parameter int BYTES_PER_LINE = 16,
    parameter int GROUP_SIZE     = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hdf_in_if.sink        i_in,
    output hdf_pkg::t_q_wr o_wr,
    input  logic          i_wr_ready
);

    localparam int LINE_W = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
    localparam int GRP_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(BYTES_PER_LINE - 1);
    localparam logic [GRP_W-1:0]  GRP_LAST  = GRP_W'(GROUP_SIZE - 1);

    logic [hdf_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [LINE_W-1:0]            r_line_ph, n_line_ph;
    logic [GRP_W-1:0]             r_grp_ph, n_grp_ph;
    logic [hdf_pkg::OFFSET_W-1:0] w_next;
    logic                         w_wrap;
    logic                         w_line_start;
    logic                         w_accept;

    assign i_in.ready = i_wr_ready;
    assign w_accept   = i_in.valid && i_wr_ready;

    // Offset of the following byte; the phases restart when it wraps to zero.
    assign w_next       = r_offset + hdf_pkg::OFFSET_W'(1);
    assign w_wrap       = (w_next == '0);
    assign w_line_start = (r_line_ph == '0);

    // Job classification for the current item.
    always_comb begin
        o_wr.valid          = i_in.valid;
        o_wr.job.is_end     = (i_in.operation == hdf_pkg::OP_END);
        o_wr.job.nl_pre     = w_line_start && (r_offset != '0);
        o_wr.job.line_start = w_line_start;
        o_wr.job.grp_sp     = w_wrap || (r_grp_ph == GRP_LAST);
        o_wr.job.offset     = r_offset;
        o_wr.job.data       = i_in.data_byte;
    end

    // Next offset and phases after an accepted transaction.
    always_comb begin
        n_offset  = r_offset;
        n_line_ph = r_line_ph;
        n_grp_ph  = r_grp_ph;
        if (w_accept) begin
            if (i_in.operation == hdf_pkg::OP_END || w_wrap) begin
                n_offset  = (i_in.operation == hdf_pkg::OP_END) ? '0 : w_next;
                n_line_ph = '0;
                n_grp_ph  = '0;
            end else begin
                n_offset  = w_next;
                n_line_ph = (r_line_ph == LINE_LAST) ? '0 : r_line_ph + LINE_W'(1);
                n_grp_ph  = (r_grp_ph == GRP_LAST) ? '0 : r_grp_ph + GRP_W'(1);
            end
        end
    end

    // Offset and phase registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_line_ph <= '0;
            r_grp_ph  <= '0;
        end else begin
            r_offset  <= n_offset;
            r_line_ph <= n_line_ph;
            r_grp_ph  <= n_grp_ph;
        end
    end

endmodule

FILE: hw/rtl/hdf_queue.sv
// ----------------------------------------------------------------------------
// Hex dump formatter job queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module hdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hdf_pkg::t_q_wr i_wr,
    output logic           o_wr_ready,
    output hdf_pkg::t_q_rd o_rd,
    input  logic           i_pop
);

    localparam int DEPTH = hdf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hdf_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_wr_ready = (r_count != CNT_FULL);
    assign w_push     = i_wr.valid && o_wr_ready;
    assign w_pop      = i_pop && (r_count != '0);

    assign o_rd.valid = (r_count != '0);
    assign o_rd.job   = r_mem[r_rd_ptr];

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/hdf_back.sv
// ----------------------------------------------------------------------------
// Hex dump formatter back end
// Steps through the characters of the head job into an output register, one
// per cycle while that register is free or its character is being taken.
// ----------------------------------------------------------------------------
module hdf_back #(
    parameter int OFFSET_DIGITS = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hdf_pkg::t_q_rd i_rd,
    output logic           o_pop,
    hdf_out_if.source      o_out
);

    localparam int DIG_W = $clog2(OFFSET_DIGITS);
    localparam logic [DIG_W-1:0] DIG_TOP = DIG_W'(OFFSET_DIGITS - 1);

    hdf_pkg::t_step             r_step, n_step;
    logic [DIG_W-1:0]           r_dig, n_dig;
    logic                       r_out_valid, n_out_valid;
    logic [6:0]                 r_out_char, n_out_char;
    logic                       r_out_last, n_out_last;
    hdf_pkg::t_step             w_cur;
    hdf_pkg::t_step             w_nxt;
    logic [hdf_pkg::WIDE_W-1:0] w_wide;
    logic [3:0]                 w_nib;
    logic [6:0]                 w_char;
    logic                       w_last;
    logic                       w_fire;

    assign o_out.valid       = r_out_valid;
    assign o_out.text_char   = r_out_char;
    assign o_out.last_of_run = r_out_last;

    // A character is produced when a job waits and the output register frees.
    assign w_fire = i_rd.valid && (!r_out_valid || o_out.ready);
    assign o_pop  = w_fire && w_last;

    assign w_wide = hdf_pkg::WIDE_W'(i_rd.job.offset);
    assign w_nib  = w_wide[4 * r_dig +: 4];

    // Current step, character and successor step.
    always_comb begin
        w_cur = r_step;
        if (r_step == hdf_pkg::S_START) begin
            if (i_rd.job.is_end || i_rd.job.nl_pre) begin
                w_cur = hdf_pkg::S_NL_PRE;
            end else if (i_rd.job.line_start) begin
                w_cur = hdf_pkg::S_DIGIT;
            end else begin
                w_cur = hdf_pkg::S_SP;
            end
        end

        w_char = hdf_pkg::CHAR_SP;
        w_nxt  = hdf_pkg::S_START;
        w_last = 1'b0;
        case (w_cur)
            hdf_pkg::S_NL_PRE: begin
                w_char = hdf_pkg::CHAR_NL;
                w_nxt  = hdf_pkg::S_DIGIT;
            end
            hdf_pkg::S_DIGIT: begin
                w_char = hdf_pkg::hex_char(w_nib);
                if (r_dig != '0) begin
                    w_nxt = hdf_pkg::S_DIGIT;
                end else if (i_rd.job.is_end) begin
                    w_nxt = hdf_pkg::S_NL_POST;
                end else begin
                    w_nxt = hdf_pkg::S_SP_OFF;
                end
            end
            hdf_pkg::S_SP_OFF: begin
                w_char = hdf_pkg::CHAR_SP;
                w_nxt  = hdf_pkg::S_SP;
            end
            hdf_pkg::S_SP: begin
                w_char = hdf_pkg::CHAR_SP;
                w_nxt  = hdf_pkg::S_HI;
            end
            hdf_pkg::S_HI: begin
                w_char = hdf_pkg::hex_char(i_rd.job.data[7:4]);
                w_nxt  = hdf_pkg::S_LO;
            end
            hdf_pkg::S_LO: begin
                w_char = hdf_pkg::hex_char(i_rd.job.data[3:0]);
                w_nxt  = i_rd.job.grp_sp ? hdf_pkg::S_GRP : hdf_pkg::S_START;
                w_last = !i_rd.job.grp_sp;
            end
            hdf_pkg::S_GRP: begin
                w_char = hdf_pkg::CHAR_SP;
                w_last = 1'b1;
            end
            hdf_pkg::S_NL_POST: begin
                w_char = hdf_pkg::CHAR_NL;
                w_last = 1'b1;
            end
            default: begin
                w_char = hdf_pkg::CHAR_SP;
                w_nxt  = hdf_pkg::S_START;
                w_last = 1'b0;
            end
        endcase
    end

    // Next sequencer state and output register contents.
    always_comb begin
        n_step      = r_step;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (w_fire) begin
            n_out_valid = 1'b1;
            n_out_char  = w_char;
            n_out_last  = w_last;
            if (w_last) begin
                n_step = hdf_pkg::S_START;
                n_dig  = DIG_TOP;
            end else begin
                n_step = w_nxt;
                if (w_cur == hdf_pkg::S_DIGIT) begin
                    n_dig = (r_dig == '0) ? DIG_TOP : r_dig - DIG_W'(1);
                end
            end
        end
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= hdf_pkg::S_START;
            r_dig       <= DIG_TOP;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_dig       <= n_dig;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload registers.
    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule
